FILE: src/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/wmf_pkg.sv
// Types and constants of the window mean / median filter
package wmf_pkg;
	localparam int MAX_HALF_DEF    = 7;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int Q_DEPTH         = 2;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_HALF = 1'b1;

	typedef enum logic [1:0] {
		MODE_MEAN   = 2'd0,
		MODE_MEDIAN = 2'd1,
		MODE_CHAIN  = 2'd2
	} mode_t;

	typedef struct packed {
		logic       last;
		mode_t      mode;
		logic [2:0] h;
	} ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RPLAN,
		ST_ESTART,
		ST_SUM,
		ST_DIV,
		ST_MED,
		ST_RESULT,
		ST_MPLAN,
		ST_EMIT,
		ST_NEXT
	} state_t;
endpackage

FILE: src/wmf_fifo.sv
// Small register queue with full and empty flags
module wmf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

FILE: src/wmf_front.sv
// Input side: accepts samples, tags them with mode and window size, queues them
module wmf_front #(
	parameter int MAX_HALF    = wmf_pkg::MAX_HALF_DEF,
	parameter int SAMPLE_BITS = wmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   sequence_last,
	input  logic [1:0]             filter_mode,
	input  logic [2:0]             half_width,
	output logic                   item_valid,
	input  logic                   item_take,
	output logic [SAMPLE_BITS-1:0] item_sample,
	output wmf_pkg::ctrl_t         item_ctrl
);
	import wmf_pkg::*;

	localparam int          QW   = SAMPLE_BITS + $bits(ctrl_t);
	localparam logic [3:0]  MaxH = 4'(MAX_HALF);

	ctrl_t         ctrl_in;
	logic [3:0]    hw4;
	logic [QW-1:0] q_out;
	logic          q_empty;

	assign hw4 = {1'b0, half_width};

	always_comb begin
		ctrl_in.last = sequence_last;
		ctrl_in.h    = (hw4 > MaxH) ? MaxH[2:0] : half_width;
		unique case (filter_mode)
			2'd1:    ctrl_in.mode = MODE_MEDIAN;
			2'd2:    ctrl_in.mode = MODE_CHAIN;
			default: ctrl_in.mode = MODE_MEAN;
		endcase
	end

	wmf_fifo #(
		.WIDTH(QW),
		.DEPTH(Q_DEPTH)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data({sample, ctrl_in}),
		.full   (full),
		.rd_en  (item_take),
		.rd_data(q_out),
		.empty  (q_empty)
	);

	assign item_valid  = !q_empty;
	assign item_sample = q_out[QW-1 -: SAMPLE_BITS];
	assign item_ctrl   = ctrl_t'(q_out[$bits(ctrl_t)-1:0]);
endmodule

FILE: src/wmf_back.sv
// Filter engine: windows, sequential sum, divider and median select
module wmf_back #(
	parameter int MAX_HALF    = wmf_pkg::MAX_HALF_DEF,
	parameter int SAMPLE_BITS = wmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_take,
	input  logic [SAMPLE_BITS-1:0] item_sample,
	input  wmf_pkg::ctrl_t         item_ctrl,
	output logic                   res_push,
	input  logic                   res_full,
	output logic [SAMPLE_BITS+1:0] res_data
);
	import wmf_pkg::*;

	localparam int WIN  = 2 * MAX_HALF + 1;
	localparam int IW   = $clog2(WIN + 1);
	localparam int XW   = $clog2(WIN);
	localparam int CW   = IW + 1;
	localparam int SUMW = SAMPLE_BITS + IW;
	localparam int DCW  = $clog2(SUMW);

	state_t state_q, state_d;

	logic signed [SAMPLE_BITS-1:0] raw_win_q  [WIN];
	logic signed [SAMPLE_BITS-1:0] mean_win_q [WIN];
	logic signed [SAMPLE_BITS-1:0] cur_buf    [WIN];
	logic [IW-1:0] raw_fill_q, mean_fill_q;

	logic                          last_q, on_mean_q, mflush_q, neg_q;
	mode_t                         mode_q;
	logic [2:0]                    h_q;
	logic [XW-1:0]                 rc_q, rend_q, mc_q, mend_q, lo_q, hi_q, idx_q;
	logic [IW-1:0]                 n_q, k_q, rem_q;
	logic signed [SUMW-1:0]        acc_q;
	logic [SUMW-1:0]               quot_q;
	logic [DCW-1:0]                dcnt_q;
	logic signed [SAMPLE_BITS-1:0] val_q;

	logic [CW-1:0] h_w, rf_w, mf_w, c_w, f_w, lo_w, hi_w, n_w;
	logic          rhas, mhas, mflush_d, use_med, hit, run_end_d;
	logic [CW-1:0] r_ctr, m_ctr;
	logic [WIN-1:0] lt_vec, le_vec;
	logic [IW-1:0]  n_lt, n_le;
	logic signed [SUMW-1:0] sum_n;
	logic [IW:0]     div_t;
	logic            div_ge;
	logic [IW-1:0]   rem_n;
	logic [SUMW-1:0] quot_n;
	logic signed [SAMPLE_BITS-1:0] q_s;

	always_comb begin
		for (int j = 0; j < WIN; j++) begin
			cur_buf[j] = on_mean_q ? mean_win_q[j] : raw_win_q[j];
		end
	end

	assign h_w   = CW'(h_q);
	assign rf_w  = CW'(raw_fill_q);
	assign mf_w  = CW'(mean_fill_q);
	assign rhas  = ((rf_w - 1'b1) >= h_w) || last_q;
	assign r_ctr = ((rf_w - 1'b1) >= h_w) ? (rf_w - 1'b1 - h_w) : '0;
	assign mflush_d = last_q && (rc_q == rend_q);
	assign mhas  = ((mf_w - 1'b1) >= h_w) || mflush_d;
	assign m_ctr = ((mf_w - 1'b1) >= h_w) ? (mf_w - 1'b1 - h_w) : '0;

	assign c_w  = CW'(on_mean_q ? mc_q : rc_q);
	assign f_w  = on_mean_q ? mf_w : rf_w;
	assign lo_w = (c_w > h_w) ? (c_w - h_w) : '0;
	assign hi_w = ((c_w + h_w) < f_w) ? (c_w + h_w) : (f_w - 1'b1);
	assign n_w  = hi_w - lo_w + 1'b1;
	assign use_med = on_mean_q || (mode_q == MODE_MEDIAN);

	always_comb begin
		for (int j = 0; j < WIN; j++) begin
			lt_vec[j] = (XW'(j) >= lo_q) && (XW'(j) <= hi_q) && (cur_buf[j] < cur_buf[idx_q]);
			le_vec[j] = (XW'(j) >= lo_q) && (XW'(j) <= hi_q) && (cur_buf[j] <= cur_buf[idx_q]);
		end
	end
	assign n_lt = IW'($countones(lt_vec));
	assign n_le = IW'($countones(le_vec));
	assign hit  = (n_lt <= k_q) && (n_le > k_q);

	assign sum_n  = acc_q + SUMW'(cur_buf[idx_q]);
	assign div_t  = {rem_q, quot_q[SUMW-1]};
	assign div_ge = div_t >= {1'b0, n_q};
	assign rem_n  = div_ge ? div_t[IW-1:0] - n_q : div_t[IW-1:0];
	assign quot_n = {quot_q[SUMW-2:0], div_ge};
	assign q_s    = quot_n[SAMPLE_BITS-1:0];

	assign run_end_d = on_mean_q ? ((mc_q == mend_q) && (!last_q || mflush_q))
	                             : (rc_q == rend_q);
	assign res_data  = {val_q, run_end_d, run_end_d && last_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		item_take = 1'b0;
		res_push  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_take = item_valid;
				if (item_valid) state_d = ST_RPLAN;
			end
			ST_RPLAN:  state_d = rhas ? ST_ESTART : ST_NEXT;
			ST_ESTART: state_d = use_med ? ST_MED : ST_SUM;
			ST_SUM:    if (idx_q == hi_q) state_d = ST_DIV;
			ST_DIV:    if (dcnt_q == DCW'(SUMW - 1)) state_d = ST_RESULT;
			ST_MED:    if (hit) state_d = ST_RESULT;
			ST_RESULT: state_d = (!on_mean_q && mode_q == MODE_CHAIN) ? ST_MPLAN : ST_EMIT;
			ST_MPLAN:  state_d = mhas ? ST_ESTART : ST_NEXT;
			ST_EMIT: begin
				res_push = !res_full;
				if (!res_full) begin
					state_d = (on_mean_q && mc_q != mend_q) ? ST_ESTART : ST_NEXT;
				end
			end
			ST_NEXT:   state_d = (rc_q == rend_q) ? ST_IDLE : ST_ESTART;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_fill_q  <= '0;
			mean_fill_q <= '0;
			on_mean_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						raw_fill_q <= (raw_fill_q == IW'(WIN)) ? raw_fill_q : raw_fill_q + 1'b1;
					end
					on_mean_q <= 1'b0;
				end
				ST_RESULT: begin
					if (!on_mean_q && mode_q == MODE_CHAIN) begin
						mean_fill_q <= (mean_fill_q == IW'(WIN)) ? mean_fill_q
						                                         : mean_fill_q + 1'b1;
					end
				end
				ST_MPLAN: on_mean_q <= mhas;
				ST_EMIT: begin
					if (!res_full && on_mean_q && mc_q == mend_q) on_mean_q <= 1'b0;
				end
				ST_NEXT: begin
					if (rc_q == rend_q && last_q) begin
						raw_fill_q  <= '0;
						mean_fill_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					last_q <= item_ctrl.last;
					mode_q <= item_ctrl.mode;
					h_q    <= item_ctrl.h;
					if (raw_fill_q == IW'(WIN)) begin
						for (int j = 0; j < WIN - 1; j++) raw_win_q[j] <= raw_win_q[j+1];
						raw_win_q[WIN-1] <= item_sample;
					end else begin
						raw_win_q[raw_fill_q[XW-1:0]] <= item_sample;
					end
				end
			end
			ST_RPLAN: begin
				rc_q   <= XW'(r_ctr);
				rend_q <= last_q ? XW'(rf_w - 1'b1) : XW'(r_ctr);
			end
			ST_ESTART: begin
				lo_q  <= XW'(lo_w);
				hi_q  <= XW'(hi_w);
				idx_q <= XW'(lo_w);
				n_q   <= IW'(n_w);
				k_q   <= IW'(n_w >> 1);
				acc_q <= '0;
			end
			ST_SUM: begin
				acc_q <= sum_n;
				idx_q <= idx_q + 1'b1;
				if (idx_q == hi_q) begin
					neg_q  <= sum_n[SUMW-1];
					quot_q <= sum_n[SUMW-1] ? SUMW'(-sum_n) : SUMW'(sum_n);
					rem_q  <= '0;
					dcnt_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q  <= rem_n;
				quot_q <= quot_n;
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == DCW'(SUMW - 1)) val_q <= neg_q ? -q_s : q_s;
			end
			ST_MED: begin
				if (hit) val_q <= cur_buf[idx_q];
				else     idx_q <= idx_q + 1'b1;
			end
			ST_RESULT: begin
				if (!on_mean_q && mode_q == MODE_CHAIN) begin
					if (mean_fill_q == IW'(WIN)) begin
						for (int j = 0; j < WIN - 1; j++) mean_win_q[j] <= mean_win_q[j+1];
						mean_win_q[WIN-1] <= val_q;
					end else begin
						mean_win_q[mean_fill_q[XW-1:0]] <= val_q;
					end
				end
			end
			ST_MPLAN: begin
				mflush_q <= mflush_d;
				mc_q     <= XW'(m_ctr);
				mend_q   <= mflush_d ? XW'(mf_w - 1'b1) : XW'(m_ctr);
			end
			ST_EMIT: begin
				if (!res_full && on_mean_q && mc_q != mend_q) mc_q <= mc_q + 1'b1;
			end
			ST_NEXT: begin
				if (rc_q != rend_q) rc_q <= rc_q + 1'b1;
			end
			default: ;
		endcase
	end
endmodule

FILE: src/window_mean_median_filter_core.sv
// Top level of the window mean / median filter: register port, front, engine, result queue
// Each sample enters a two-deep input queue and is filtered over a centered window of
// 2*half_width+1 samples, cut off at the ends of a sequence. One engine works on one sample
// at a time. A sample is taken in the idle step and planned in the plan step. A mean result
// then passes start, a sum of the n window samples added one a cycle, a one-bit-a-cycle
// divider of SAMPLE_BITS + 4 steps at the default window depth, then result, emit and next.
// A median result ranks one candidate against the window each cycle. In mode 2 each mean
// adds a planning step and is followed by the median passes over the means that it enables.
// Results wait in a two-deep queue, and the engine holds in its emit step while that queue is
// full. A sample marked last flushes up to half_width+1 results (up to 2*half_width+1 in
// mode 2), and run_end marks the last result of each sample.
module window_mean_median_filter_core #(
	parameter int MAX_HALF    = wmf_pkg::MAX_HALF_DEF,
	parameter int SAMPLE_BITS = wmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   push,
	output logic                   full,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   sequence_last,
	input  logic                   pop,
	output logic                   empty,
	output logic [SAMPLE_BITS-1:0] filtered,
	output logic                   run_end,
	output logic                   sequence_end
);
	import wmf_pkg::*;

	`include "assert_macros.svh"

	logic [1:0]             filter_mode_q;
	logic [2:0]             half_width_q;
	logic                   item_valid, item_take;
	logic [SAMPLE_BITS-1:0] item_sample;
	ctrl_t                  item_ctrl;
	logic                   res_push, res_full;
	logic [SAMPLE_BITS+1:0] res_data, res_out;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q <= 2'd0;
			half_width_q  <= 3'd1;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_MODE: filter_mode_q <= pwdata[1:0];
				REG_HALF: half_width_q  <= pwdata[2:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE: prdata = {30'd0, filter_mode_q};
			REG_HALF: prdata = {29'd0, half_width_q};
		endcase
	end

	wmf_front #(
		.MAX_HALF   (MAX_HALF),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample       (sample),
		.sequence_last(sequence_last),
		.filter_mode  (filter_mode_q),
		.half_width   (half_width_q),
		.item_valid   (item_valid),
		.item_take    (item_take),
		.item_sample  (item_sample),
		.item_ctrl    (item_ctrl)
	);

	wmf_back #(
		.MAX_HALF   (MAX_HALF),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item_sample(item_sample),
		.item_ctrl  (item_ctrl),
		.res_push   (res_push),
		.res_full   (res_full),
		.res_data   (res_data)
	);

	wmf_fifo #(
		.WIDTH(SAMPLE_BITS + 2),
		.DEPTH(Q_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_data),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_out),
		.empty  (empty)
	);

	assign filtered     = res_out[SAMPLE_BITS+1:2];
	assign run_end      = res_out[1];
	assign sequence_end = res_out[0];

	`ASSERT_IMPL(a_res_no_overflow, res_push, !res_full, "result written into full queue")
	`ASSERT_IMPL(a_take_valid, item_take, item_valid, "engine took item from empty queue")
	`ASSERT_IMPL(a_seq_end_run_end, !empty && sequence_end, run_end, "sequence end without run end")
	`ASSERT_NEXT(a_take_one, item_take, !item_take, "engine took two items back to back")
endmodule

FILE: sim/testbench.sv
// Testbench for the window mean / median filter: self-predicting stimulus and result checks
`timescale 1ns / 100ps

module testbench;
	import wmf_pkg::*;

	localparam logic [2:0] ADDR_MODE = {REG_MODE, 2'b00};
	localparam logic [2:0] ADDR_HALF = {REG_HALF, 2'b00};
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int WIN = 2 * MAX_HALF_DEF + 1;
	localparam int SETTLE_CYCLES = 400;

	typedef struct {
		logic [15:0] filtered;
		logic        run_end;
		logic        sequence_end;
	} filt_result_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic push, full, pop, empty;
	logic [15:0] sample, filtered;
	logic sequence_last, run_end, sequence_end;

	window_mean_median_filter_core u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .sample(sample), .sequence_last(sequence_last),
		.pop(pop), .empty(empty), .filtered(filtered), .run_end(run_end),
		.sequence_end(sequence_end)
	);

	filt_result_t pending_results[$];
	int error_count = 0;
	int hold_cycles = 0;
	int burst_left = 0;

	int raw_win[WIN];
	int raw_fill = 0;
	int mean_win[WIN];
	int mean_fill = 0;
	logic [1:0] cur_mode = MODE_MEAN;
	int cur_half = 1;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic int window_value(input int w[WIN], input int fill, input int c,
			input int h, input bit median);
		int lo, hi, n, sum, i, j, key;
		int tmp[WIN];
		lo = c > h ? c - h : 0;
		hi = c + h < fill ? c + h : fill - 1;
		n = 0;
		sum = 0;
		for (i = lo; i <= hi && i < WIN; i++) begin
			tmp[n] = w[i];
			n++;
			sum += w[i];
		end
		if (n == 0) return 0;
		if (!median) return sum / n;
		for (i = 1; i < n; i++) begin
			key = tmp[i];
			j = i;
			while (j > 0 && tmp[j-1] > key) begin
				tmp[j] = tmp[j-1];
				j--;
			end
			tmp[j] = key;
		end
		return tmp[n/2];
	endfunction

	task automatic window_push(inout int w[WIN], inout int fill, input int v);
		int i;
		if (fill >= WIN) begin
			for (i = 0; i + 1 < WIN; i++) w[i] = w[i+1];
			w[WIN-1] = v;
			fill = WIN;
		end else begin
			w[fill] = v;
			fill++;
		end
	endtask

	task automatic window_emit(input int w[WIN], input int fill, input int h, input bit last,
			input bit median, inout int vals[$]);
		int c, start;
		if (fill == 0) return;
		if (!last) begin
			if (fill - 1 >= h) vals.push_back(window_value(w, fill, fill - 1 - h, h, median));
			return;
		end
		start = (fill - 1 >= h) ? fill - 1 - h : 0;
		for (c = start; c < fill; c++) vals.push_back(window_value(w, fill, c, h, median));
	endtask

	task automatic predict_filter(input logic [15:0] s, input bit last);
		int vals[$];
		int means[$];
		int k;
		filt_result_t r;
		window_push(raw_win, raw_fill, int'($signed(s)));
		if (cur_mode == MODE_MEDIAN) begin
			window_emit(raw_win, raw_fill, cur_half, last, 1'b1, vals);
		end else if (cur_mode == MODE_CHAIN) begin
			window_emit(raw_win, raw_fill, cur_half, last, 1'b0, means);
			for (k = 0; k < means.size(); k++) begin
				window_push(mean_win, mean_fill, means[k]);
				window_emit(mean_win, mean_fill, cur_half, last && k + 1 == means.size(),
					1'b1, vals);
			end
		end else begin
			window_emit(raw_win, raw_fill, cur_half, last, 1'b0, vals);
		end
		for (k = 0; k < vals.size(); k++) begin
			r.filtered = vals[k][15:0];
			r.run_end = (k + 1 == vals.size());
			r.sequence_end = r.run_end && last;
			pending_results.push_back(r);
		end
		if (last) begin
			raw_fill = 0;
			mean_fill = 0;
		end
	endtask

	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (pending_results.size() == 0) begin
					report("unexpected transfer", filtered, 16'h0);
				end else begin
					filt_result_t w;
					w = pending_results.pop_front();
					if (filtered !== w.filtered) report("filtered", filtered, w.filtered);
					if (run_end !== w.run_end) report("run_end", run_end, w.run_end);
					if (sequence_end !== w.sequence_end)
						report("sequence_end", sequence_end, w.sequence_end);
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				pop <= 1'b0;
			end else if ((($time / 512) % 3) == 0) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	task automatic send_item(input logic [15:0] s, input bit last);
		push <= 1'b1;
		sample <= s;
		sequence_last <= last;
		do @(posedge clk); while (full);
		predict_filter(s, last);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 20);
			repeat ($urandom_range(0, 6)) begin
				push <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_filter(input logic [1:0] mode, input int h);
		settle();
		reg_write(ADDR_MODE, {30'd0, mode});
		reg_write(ADDR_HALF, h);
		cur_mode = mode;
		cur_half = h;
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 4))
			0: return 16'h7fff - 16'($urandom_range(0, 3));
			1: return 16'h8000 + 16'($urandom_range(0, 3));
			2: return 16'($urandom_range(0, 40)) - 16'd20;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_sequence(input int len);
		int i;
		for (i = 0; i < len; i++) send_item(rand_sample(), i == len - 1);
	endtask

	task automatic test_reset_defaults();
		send_item(16'd10, 1'b0);
		send_item(-16'sd10, 1'b0);
		send_item(16'd7, 1'b1);
	endtask

	task automatic test_directed();
		set_filter(MODE_MEAN, 0);
		send_item(16'h7fff, 1'b1);
		set_filter(MODE_MEAN, 7);
		send_item(16'h7fff, 1'b0);
		send_item(16'h7fff, 1'b0);
		send_item(16'h8000, 1'b1);
		set_filter(MODE_MEDIAN, 1);
		send_item(16'h8000, 1'b0);
		send_item(16'h7fff, 1'b0);
		send_item(16'h0000, 1'b0);
		send_item(16'hffff, 1'b1);
		set_filter(MODE_CHAIN, 2);
		send_item(16'h7fff, 1'b0);
		send_item(16'h8000, 1'b0);
		send_item(16'h0005, 1'b0);
		send_item(16'hfffb, 1'b0);
		send_item(16'h0001, 1'b0);
		send_item(16'h1234, 1'b1);
		set_filter(MODE_SPARE, 3);
		send_item(16'h8001, 1'b0);
		send_item(16'h7ffe, 1'b0);
		send_item(16'h0003, 1'b1);
		set_filter(MODE_CHAIN, 7);
		send_sequence(3);
	endtask

	task automatic test_mid_change();
		set_filter(MODE_MEAN, 2);
		send_sequence(6);
		send_item(rand_sample(), 1'b0);
		send_item(rand_sample(), 1'b0);
		set_filter(MODE_CHAIN, 1);
		send_item(rand_sample(), 1'b0);
		send_item(rand_sample(), 1'b0);
		set_filter(MODE_MEDIAN, 5);
		send_item(rand_sample(), 1'b0);
		send_item(rand_sample(), 1'b1);
	endtask

	task automatic test_backpressure();
		set_filter(MODE_MEDIAN, 0);
		hold_cycles = 400;
		send_sequence(20);
	endtask

	task automatic test_drain_pause();
		set_filter(MODE_MEAN, 1);
		send_sequence(5);
		push <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		send_sequence(5);
	endtask

	task automatic test_random();
		int sent, len;
		sent = 0;
		while (sent < 280) begin
			if ($urandom_range(0, 2) == 0)
				set_filter(2'($urandom_range(0, 3)), int'($urandom_range(0, 7)));
			len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 30) : $urandom_range(1, 12);
			send_sequence(len);
			sent += len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		sample = '0;
		sequence_last = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_mid_change();
		test_backpressure();
		test_drain_pause();
		test_random();
		settle();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
